### src/sst_pkg.sv
// Package: shared types and constants for the sorted score table.
`timescale 1ns / 1ps
`default_nettype none
package sst_pkg;
	localparam int Capacity = 16;
	localparam int IdxW = $clog2(Capacity);
	localparam int CntW = $clog2(Capacity + 1);

	typedef enum logic [2:0] {
		REQ_INSERT = 3'd0,
		REQ_LOOKUP = 3'd1,
		REQ_UPDATE = 3'd2,
		REQ_REMOVE = 3'd3,
		REQ_PURGE  = 3'd4,
		REQ_LISTA  = 3'd5,
		REQ_LISTD  = 3'd6,
		REQ_NONE   = 3'd7
	} req_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [15:0] key;
		logic [15:0] score;
		logic [15:0] threshold;
	} req_beat_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] out_key;
		logic [15:0] out_score;
		logic [4:0]  removed_count;
		logic        last;
	} rsp_beat_t;
endpackage
`default_nettype wire

### src/sst_stream_if.sv
// Interface: valid/ready stream channel carrying one beat type.
`timescale 1ns / 1ps
`default_nettype none
interface sst_req_if;
	logic                  valid;
	logic                  ready;
	sst_pkg::req_beat_t    data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sst_rsp_if;
	logic                  valid;
	logic                  ready;
	sst_pkg::rsp_beat_t    data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### src/sorted_score_table_top.sv
// Top level: sequenced sorted score table.
//
// Usage: requests enter on req (valid/ready), one beat per request. Results
// leave on rsp, one beat per result; list requests give one beat per entry
// with last set on the final one, all others give a single beat. req_type 7
// gives no result.
// Operation: a request walks the table one slot per cycle, comparing or
// moving one slot at a time. Insert finds its position, then opens a hole
// from the top; remove closes the gap; an update whose entry has to move
// removes it and inserts it anew. Purge drops the lowest entry, closes the
// gap and checks again. List gives one beat per cycle while rsp is not
// stalled.
// The block takes one request at a time; req.ready is low while it works
// and while a result beat is still waiting.
// Reset clears the entry count; storage is not cleared and only entries
// below the count are ever read, so no clearing pass is needed.
// When the receiver stalls rsp, the result register holds and the
// sequencer waits; nothing is lost.
`timescale 1ns / 1ps
`default_nettype none
module sorted_score_table_top (
	input  wire logic clk,
	input  wire logic arst_n,
	sst_req_if.sink   req,
	sst_rsp_if.source rsp
);
	typedef enum logic [3:0] {
		S_IDLE, S_FIND, S_SHIFTL, S_INSPOS, S_SHIFTR, S_PURGE, S_LIST, S_OUT
	} state_t;

	state_t state_q;
	logic [15:0] key_q [sst_pkg::Capacity];
	logic [15:0] score_q [sst_pkg::Capacity];
	logic [sst_pkg::CntW-1:0] count_q;
	logic [sst_pkg::CntW-1:0] idx_q;   // scan index
	logic [sst_pkg::CntW-1:0] pos_q;   // target position
	logic [sst_pkg::CntW-1:0] n_q;
	sst_pkg::req_beat_t r_q;
	sst_pkg::rsp_beat_t o_q;
	logic ovalid_q;
	logic reins_q;   // after shifting left, reinsert the entry
	logic [sst_pkg::IdxW-1:0] ix;
	logic [sst_pkg::IdxW-1:0] ixm;
	logic [sst_pkg::IdxW-1:0] px;
	logic emit_w;
	logic full_ins_w;
	logic empty_req_w;

	assign ix  = idx_q[sst_pkg::IdxW-1:0];
	assign ixm = ix - 1'b1;
	assign px  = pos_q[sst_pkg::IdxW-1:0];

	// Load a result beat when the result register is free or drains now.
	assign emit_w = (state_q == S_LIST || state_q == S_OUT) && (!ovalid_q || rsp.ready);
	assign full_ins_w = (req.data.req_type == sst_pkg::REQ_INSERT)
		&& (count_q == sst_pkg::CntW'(sst_pkg::Capacity));
	assign empty_req_w = (req.data.req_type != sst_pkg::REQ_INSERT) && (count_q == '0);

	assign req.ready = (state_q == S_IDLE) && !ovalid_q;
	assign rsp.valid = ovalid_q;
	assign rsp.data  = o_q;

	// Sequencer: one slot compare or one slot move per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			ovalid_q <= 1'b0;
			idx_q    <= '0;
			pos_q    <= '0;
			n_q      <= '0;
			reins_q  <= 1'b0;
		end else begin
			if (ovalid_q && rsp.ready && !emit_w) ovalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (req.valid && req.ready) begin
						r_q   <= req.data;
						idx_q <= '0;
						n_q   <= '0;
						reins_q <= 1'b0;
						o_q   <= '{status: full_ins_w ? sst_pkg::ST_FULL :
							(empty_req_w ? sst_pkg::ST_EMPTY : sst_pkg::ST_OK),
							out_key: full_ins_w ? req.data.key : 16'd0,
							out_score: full_ins_w ? req.data.score : 16'd0,
							removed_count: 5'd0, last: 1'b1};
						if (req.data.req_type == sst_pkg::REQ_NONE) begin
							state_q <= S_IDLE;
						end else if (req.data.req_type == sst_pkg::REQ_INSERT) begin
							if (full_ins_w) state_q <= S_OUT;
							else state_q <= S_INSPOS;
						end else if (empty_req_w) begin
							state_q <= S_OUT;
						end else if (req.data.req_type == sst_pkg::REQ_PURGE)
							state_q <= S_PURGE;
						else if (req.data.req_type == sst_pkg::REQ_LISTA
							|| req.data.req_type == sst_pkg::REQ_LISTD)
							state_q <= S_LIST;
						else state_q <= S_FIND;
					end
				end
				S_FIND: begin
					if (idx_q == count_q) begin
						o_q.status  <= sst_pkg::ST_NOT_FOUND;
						o_q.out_key <= r_q.key;
						state_q <= S_OUT;
					end else if (key_q[ix] == r_q.key) begin
						o_q.out_key <= r_q.key;
						if (r_q.req_type == sst_pkg::REQ_LOOKUP) begin
							o_q.out_score <= score_q[ix];
							state_q <= S_OUT;
						end else if (r_q.req_type == sst_pkg::REQ_REMOVE) begin
							o_q.out_score <= score_q[ix];
							pos_q <= idx_q;
							state_q <= S_SHIFTL;
						end else begin
							o_q.out_score <= r_q.score;
							if ((idx_q != '0 && r_q.score < score_q[ixm]) ||
								(idx_q + 1'b1 < count_q &&
								r_q.score > score_q[ix + 1'b1])) begin
								pos_q <= idx_q;
								reins_q <= 1'b1;
								state_q <= S_SHIFTL;
							end else begin
								score_q[ix] <= r_q.score;
								state_q <= S_OUT;
							end
						end
					end else idx_q <= idx_q + 1'b1;
				end
				// Close the gap at pos_q one slot per cycle.
				S_SHIFTL: begin
					if (pos_q + 1'b1 < count_q) begin
						key_q[px]   <= key_q[px + 1'b1];
						score_q[px] <= score_q[px + 1'b1];
						pos_q <= pos_q + 1'b1;
					end else begin
						count_q <= count_q - 1'b1;
						idx_q <= '0;
						// a purge step returns to the purge check
						if (reins_q) state_q <= S_INSPOS;
						else if (r_q.req_type == sst_pkg::REQ_PURGE) state_q <= S_PURGE;
						else state_q <= S_OUT;
					end
				end
				// Find the first slot whose score is at least the new one.
				S_INSPOS: begin
					if (idx_q < count_q && score_q[ix] < r_q.score)
						idx_q <= idx_q + 1'b1;
					else begin
						pos_q <= count_q;
						state_q <= S_SHIFTR;
					end
				end
				// Open a hole at idx_q, moving one slot per cycle from the top.
				S_SHIFTR: begin
					if (pos_q > idx_q) begin
						key_q[px]   <= key_q[px - 1'b1];
						score_q[px] <= score_q[px - 1'b1];
						pos_q <= pos_q - 1'b1;
					end else begin
						key_q[px]   <= r_q.key;
						score_q[px] <= r_q.score;
						count_q <= count_q + 1'b1;
						o_q.out_key   <= r_q.key;
						o_q.out_score <= r_q.score;
						state_q <= S_OUT;
					end
				end
				// Drop the lowest entry while it is below the threshold.
				S_PURGE: begin
					if (count_q != '0 && score_q[0] < r_q.threshold) begin
						n_q <= n_q + 1'b1;
						pos_q <= '0;
						idx_q <= '0;
						state_q <= S_SHIFTL;
					end else begin
						o_q.removed_count <= 5'(n_q);
						state_q <= S_OUT;
					end
				end
				// Emit one entry per beat.
				S_LIST: begin
					if (emit_w) begin
						ovalid_q <= 1'b1;
						o_q.status <= sst_pkg::ST_OK;
						if (r_q.req_type == sst_pkg::REQ_LISTA) begin
							o_q.out_key   <= key_q[ix];
							o_q.out_score <= score_q[ix];
						end else begin
							o_q.out_key   <= key_q[sst_pkg::IdxW'(count_q - 1'b1 - idx_q)];
							o_q.out_score <= score_q[sst_pkg::IdxW'(count_q - 1'b1 - idx_q)];
						end
						o_q.last <= (idx_q + 1'b1 == count_q);
						idx_q <= idx_q + 1'b1;
						if (idx_q + 1'b1 == count_q) state_q <= S_IDLE;
					end
				end
				S_OUT: begin
					if (emit_w) begin
						ovalid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Checks on the sequencer.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= sst_pkg::CntW'(sst_pkg::Capacity))
		else $error("entry count beyond capacity");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready ||
		$past(req.data.req_type) == sst_pkg::REQ_NONE)
		else $error("accepted request without going busy");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> rsp.valid && $stable(rsp.data))
		else $error("stalled result changed");
endmodule
`default_nettype wire
